// File: hw/rtl/mpool_pkg.sv
// Shared types, constants and the float compare for the max pooling block.
`timescale 1ns / 1ps
`default_nettype none
package mpool_pkg;

    localparam logic [31:0] NEG_FLT_MAX = 32'hFF7F_FFFF;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_R    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_C    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_H  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_W  = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [3:0] win_rows;
        logic [3:0] win_cols;
        logic [3:0] stride_r;
        logic [3:0] stride_c;
        logic [2:0] pad_r;
        logic [2:0] pad_c;
        logic [6:0] plane_h;
        logic [6:0] plane_w;
    } cfg_t;

    typedef struct packed {
        logic wr_pixel;   // store the accepted write beat
        logic latch_pos;  // capture the query position
        logic check;      // evaluate validity, set window base, clear accumulator
        logic step;       // issue one tap and advance the tap counters
        logic load_out;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic last_tap;
        logic out_free;
    } status_t;

    // Ordered greater-than: false for a NaN on the left, and +0 equals -0.
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic zeros;
        logic r;
        a_nan = (&a[30:23]) && (|a[22:0]);
        zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || zeros) begin
            r = 1'b0;
        end else begin
            case ({a[31], b[31]})
                2'b00:   r = a[30:0] > b[30:0];
                2'b01:   r = 1'b1;
                2'b10:   r = 1'b0;
                2'b11:   r = a[30:0] < b[30:0];
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/max_pool_2d_argmax.sv
// Top level of the 2-D max pooling block with argmax over one stored plane.
// Write beat: stored on the accepting edge; the next beat can be taken in the next cycle.
// Query beat: passes through check, scan over every tap, drain and finish; the
//   result is registered once the output register is free, and a bad query
//   skips scan and drain. The block takes no new beat until the query is done.
// Reset (aresetn low, synchronous) restores kernel 2x2, stride 2x2, no padding,
// plane 64x64 and empties the output; the plane memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2d_argmax #(
    parameter int MAX_PLANE_H = 64,
    parameter int MAX_PLANE_W = 64,
    parameter int MAX_KERNEL  = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mpool_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mpool_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input beats
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // pixel_row[5:0], pixel_col[11:6], pixel_value[43:12], out_row[49:44],
    // out_col[55:50]
    input  wire logic [55:0]                          s_tdata,
    // action[0]
    input  wire logic                                 s_tuser,
    // result beats
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // max_value[31:0], max_index[43:32], zero fill[47:44]
    output logic [47:0]                               m_tdata,
    // window_empty[0], bad_query[1]
    output logic [1:0]                                m_tuser
);
    import mpool_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers, no read-back: taken while idle by user rule, not enforced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_rows <= 4'd2;
            cfg_reg.win_cols <= 4'd2;
            cfg_reg.stride_r <= 4'd2;
            cfg_reg.stride_c <= 4'd2;
            cfg_reg.pad_r    <= 3'd0;
            cfg_reg.pad_c    <= 3'd0;
            cfg_reg.plane_h  <= 7'd64;
            cfg_reg.plane_w  <= 7'd64;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KERNEL_H: cfg_reg.win_rows <= cfg_wr_data[3:0];
                REG_KERNEL_W: cfg_reg.win_cols <= cfg_wr_data[3:0];
                REG_STRIDE_R: cfg_reg.stride_r <= cfg_wr_data[3:0];
                REG_STRIDE_C: cfg_reg.stride_c <= cfg_wr_data[3:0];
                REG_PAD_R:    cfg_reg.pad_r    <= cfg_wr_data[2:0];
                REG_PAD_C:    cfg_reg.pad_c    <= cfg_wr_data[2:0];
                REG_PLANE_H:  cfg_reg.plane_h  <= cfg_wr_data;
                REG_PLANE_W:  cfg_reg.plane_w  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: accepts a beat only when idle, then walks the window for a query
    mpool_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: plane memory, tap addressing, running max, output register
    mpool_dp #(
        .MAX_PLANE_H (MAX_PLANE_H),
        .MAX_PLANE_W (MAX_PLANE_W),
        .MAX_KERNEL  (MAX_KERNEL)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );
endmodule
`default_nettype wire

// File: hw/rtl/mpool_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mpool_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/mpool_ctrl.sv
// Sequencer for pixel writes and window scans.
`timescale 1ns / 1ps
`default_nettype none
module mpool_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                action,
    output logic                     s_tready,
    input  wire mpool_pkg::status_t  status,
    output mpool_pkg::cmd_t          cmd
);
    import mpool_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (action == ACT_QUERY) begin
                        cmd.latch_pos = 1'b1;
                        state_next    = ST_CHECK;
                    end else begin
                        cmd.wr_pixel = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = status.bad ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/mpool_dp.sv
// Datapath: plane memory, window addressing, running maximum and output register.
`timescale 1ns / 1ps
`default_nettype none
module mpool_dp #(
    parameter int MAX_PLANE_H = 64,
    parameter int MAX_PLANE_W = 64,
    parameter int MAX_KERNEL  = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mpool_pkg::cfg_t    cfg,
    input  wire mpool_pkg::cmd_t    cmd,
    output mpool_pkg::status_t      status,
    input  wire logic [55:0]        s_tdata,
    output logic [47:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready
);
    import mpool_pkg::*;

    localparam int DEPTH = MAX_PLANE_H * MAX_PLANE_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_PLANE_H > 1) ? $clog2(MAX_PLANE_H) : 1;
    localparam int CW    = (MAX_PLANE_W > 1) ? $clog2(MAX_PLANE_W) : 1;

    logic [5:0]  in_row, in_col, in_orow, in_ocol;
    logic [31:0] in_value;
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = s_tdata[43:12];
    assign in_orow  = s_tdata[49:44];
    assign in_ocol  = s_tdata[55:50];

    // Write port
    logic          wr_in_range, ram_we;
    logic [AW-1:0] waddr;
    assign wr_in_range = (11'(in_row) < 11'(MAX_PLANE_H)) && (11'(in_col) < 11'(MAX_PLANE_W));
    assign ram_we      = cmd.wr_pixel && wr_in_range;
    assign waddr       = AW'(21'(in_row) * 21'(MAX_PLANE_W) + 21'(in_col));

    // Query position
    logic [5:0] orow_reg, ocol_reg;
    always_ff @(posedge aclk) begin
        if (cmd.latch_pos) begin
            orow_reg <= in_orow;
            ocol_reg <= in_ocol;
        end
    end

    // Validity check: orow < out_h is the same as orow*stride + kernel <= padded
    logic [9:0]  row_off, col_off;
    logic [7:0]  ext_rows, ext_cols;
    logic        cfg_bad, pos_bad, bad_now;
    assign row_off  = 10'(orow_reg) * 10'(cfg.stride_r);
    assign col_off  = 10'(ocol_reg) * 10'(cfg.stride_c);
    assign ext_rows = 8'(cfg.plane_h) + {4'd0, cfg.pad_r, 1'b0};
    assign ext_cols = 8'(cfg.plane_w) + {4'd0, cfg.pad_c, 1'b0};
    assign cfg_bad  = (cfg.win_rows == 4'd0) || (5'(cfg.win_rows) > 5'(MAX_KERNEL)) ||
                      (cfg.win_cols == 4'd0) || (5'(cfg.win_cols) > 5'(MAX_KERNEL)) ||
                      (cfg.stride_r == 4'd0) || (cfg.stride_c == 4'd0) ||
                      (cfg.plane_h == 7'd0) || (11'(cfg.plane_h) > 11'(MAX_PLANE_H)) ||
                      (cfg.plane_w == 7'd0) || (11'(cfg.plane_w) > 11'(MAX_PLANE_W)) ||
                      (ext_rows < 8'(cfg.win_rows)) || (ext_cols < 8'(cfg.win_cols));
    assign pos_bad  = (11'(row_off) + 11'(cfg.win_rows) > 11'(ext_rows)) ||
                      (11'(col_off) + 11'(cfg.win_cols) > 11'(ext_cols));
    assign bad_now  = cfg_bad || pos_bad;

    logic               bad_reg;
    logic signed [11:0] base_r_reg, base_c_reg;
    logic [3:0]         kh_cnt_reg, kw_cnt_reg;
    logic               last_kw, last_tap;

    assign last_kw  = (kw_cnt_reg == cfg.win_cols - 4'd1);
    assign last_tap = last_kw && (kh_cnt_reg == cfg.win_rows - 4'd1);

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            bad_reg    <= bad_now;
            base_r_reg <= $signed({2'b00, row_off}) - $signed({9'd0, cfg.pad_r});
            base_c_reg <= $signed({2'b00, col_off}) - $signed({9'd0, cfg.pad_c});
            kh_cnt_reg <= '0;
            kw_cnt_reg <= '0;
        end else if (cmd.step) begin
            if (last_kw) begin
                kw_cnt_reg <= '0;
                kh_cnt_reg <= kh_cnt_reg + 4'd1;
            end else begin
                kw_cnt_reg <= kw_cnt_reg + 4'd1;
            end
        end
    end

    // Tap address
    logic signed [11:0] ih, iw;
    logic               tap_hit, ram_re;
    logic [AW-1:0]      raddr;
    logic [11:0]        tap_idx;
    logic [17:0]        flat;
    assign ih      = base_r_reg + $signed({8'd0, kh_cnt_reg});
    assign iw      = base_c_reg + $signed({8'd0, kw_cnt_reg});
    assign tap_hit = !ih[11] && !iw[11] &&
                     (ih[10:0] < 11'(cfg.plane_h)) && (iw[10:0] < 11'(cfg.plane_w));
    assign ram_re  = cmd.step && tap_hit;
    assign raddr   = AW'(21'(ih[RW-1:0]) * 21'(MAX_PLANE_W) + 21'(iw[CW-1:0]));
    assign flat    = 18'(ih[10:0]) * 18'(cfg.plane_w) + 18'(iw[10:0]);
    assign tap_idx = flat[11:0];

    logic [31:0] rdata;
    mpool_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_plane (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Running maximum, one tap behind the read
    logic        tap_vld_reg;
    logic [11:0] tap_idx_reg;
    logic [31:0] best_reg;
    logic [11:0] best_idx_reg;
    logic        any_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_vld_reg <= 1'b0;
        end else begin
            tap_vld_reg <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        tap_idx_reg <= tap_idx;
        if (cmd.check) begin
            best_reg     <= NEG_FLT_MAX;
            best_idx_reg <= '0;
            any_reg      <= 1'b0;
        end else if (tap_vld_reg) begin
            any_reg <= 1'b1;
            if (fp_gt(rdata, best_reg)) begin
                best_reg     <= rdata;
                best_idx_reg <= tap_idx_reg;
            end
        end
    end

    // Output register
    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic [1:0]  m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (bad_reg) begin
                m_data_reg <= {4'd0, 12'd0, NEG_FLT_MAX};
                m_user_reg <= 2'b10;
            end else begin
                m_data_reg <= {4'd0, best_idx_reg, best_reg};
                m_user_reg <= {1'b0, !any_reg};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign status.bad      = bad_now;
    assign status.last_tap = last_tap;
    assign status.out_free = !m_valid_reg || m_tready;
endmodule
`default_nettype wire

// File: bench/max_pool_2d_argmax_test.sv
// Self-checking bench for the 2-D max pooling block with argmax.
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2d_argmax_test;
    import mpool_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [11:0] index;
        logic        empty;
        logic        bad;
    } pool_res_t;

    // Scoreboard: own copy of plane and registers, queue of expected results.
    class pool_scoreboard;
        logic [31:0] plane [0:4095];
        bit   [3:0]  kh, kw, sr, sc;
        bit   [2:0]  pr, pc;
        bit   [6:0]  ph, pw;
        pool_res_t   pending [$];
        int          mismatches;
        int          results_seen;

        function void restore();
            kh = 2; kw = 2; sr = 2; sc = 2; pr = 0; pc = 0; ph = 64; pw = 64;
        endfunction

        function void set_reg(logic [2:0] idx, logic [6:0] v);
            case (idx)
                REG_KERNEL_H: kh = v[3:0];
                REG_KERNEL_W: kw = v[3:0];
                REG_STRIDE_R: sr = v[3:0];
                REG_STRIDE_C: sc = v[3:0];
                REG_PAD_R:    pr = v[2:0];
                REG_PAD_C:    pc = v[2:0];
                REG_PLANE_H:  ph = v;
                default:      pw = v;
            endcase
        endfunction

        // Ordered greater-than over IEEE single bits; NaN never wins.
        function bit greater(logic [31:0] a, logic [31:0] b);
            if ((&a[30:23]) && (|a[22:0])) return 0;
            if ((&b[30:23]) && (|b[22:0])) return 0;
            if (a[30:0] == 0 && b[30:0] == 0) return 0;
            case ({a[31], b[31]})
                2'b00: return a[30:0] > b[30:0];
                2'b01: return 1;
                2'b10: return 0;
                default: return a[30:0] < b[30:0];
            endcase
        endfunction

        function void note_beat(logic act, logic [55:0] d);
            pool_res_t r;
            int hp, wp, oh, ow, br, bc, y, x;
            bit any;
            if (act == ACT_WRITE) begin
                plane[{d[5:0], d[11:6]}] = d[43:12];
                return;
            end
            r = '{NEG_FLT_MAX, 12'd0, 1'b0, 1'b0};
            hp = ph + 2 * pr;
            wp = pw + 2 * pc;
            any = 0;
            if (kh == 0 || kh > 8 || kw == 0 || kw > 8 || sr == 0 || sc == 0 ||
                ph == 0 || ph > 64 || pw == 0 || pw > 64 || hp < kh || wp < kw) begin
                r.bad = 1;
            end else begin
                oh = (hp - kh) / sr + 1;
                ow = (wp - kw) / sc + 1;
                if (d[49:44] >= oh || d[55:50] >= ow) r.bad = 1;
            end
            if (!r.bad) begin
                br = int'(d[49:44]) * int'(sr) - int'(pr);
                bc = int'(d[55:50]) * int'(sc) - int'(pc);
                for (y = br; y < br + int'(kh); y++)
                    for (x = bc; x < bc + int'(kw); x++)
                        if (y >= 0 && x >= 0 && y < int'(ph) && x < int'(pw)) begin
                            any = 1;
                            if (greater(plane[y * 64 + x], r.value)) begin
                                r.value = plane[y * 64 + x];
                                r.index = 12'(y * int'(pw) + x);
                            end
                        end
                r.empty = !any;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] exp_v, logic [47:0] got);
            mismatches++;
            $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got, $realtime);
        endtask

        task check_beat(logic [47:0] d, logic [1:0] u);
            pool_res_t e;
            results_seen++;
            if (pending.size() == 0) begin
                report("unexpected result beat", 0, d);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.value) report("max_value", e.value, 48'(d[31:0]));
            if (d[43:32] !== e.index) report("max_index", 32'(e.index), 48'(d[43:32]));
            if (u[0] !== e.empty) report("window_empty", 32'(e.empty), 48'(u[0]));
            if (u[1] !== e.bad) report("bad_query", 32'(e.bad), 48'(u[1]));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = 0;
    logic [6:0]  cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    pool_scoreboard board = new();
    int send_idle_pct, recv_idle_pct;
    int queries_sent;

    max_pool_2d_argmax i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Sample both channels on the rising edge; the driver only moves on falling edges.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
        end
    end

    // Receiver stall pattern, redrawn every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one beat, hold it until taken, then drop valid and idle at random.
    task automatic send_beat(logic act, logic [55:0] d);
        s_tuser  = act;
        s_tdata  = d;
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (act == ACT_QUERY) queries_sent++;
        s_tvalid = 0;
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
    endtask

    task automatic write_pixel(int r, int c, logic [31:0] v);
        send_beat(ACT_WRITE, {12'd0, v, c[5:0], r[5:0]});
    endtask

    task automatic query(int r, int c);
        send_beat(ACT_QUERY, {c[5:0], r[5:0], 32'h0, 12'h0});
    endtask

    // Let the block drain before touching the registers.
    task automatic settle();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] v);
        cfg_wr_en   = 1;
        cfg_index   = idx;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 0;
        board.set_reg(idx, v);
    endtask

    task automatic setup(int khv, int kwv, int srv, int scv, int prv, int pcv,
                         int phv, int pwv);
        settle();
        write_reg(REG_KERNEL_H, 7'(khv));
        write_reg(REG_KERNEL_W, 7'(kwv));
        write_reg(REG_STRIDE_R, 7'(srv));
        write_reg(REG_STRIDE_C, 7'(scv));
        write_reg(REG_PAD_R, 7'(prv));
        write_reg(REG_PAD_C, 7'(pcv));
        write_reg(REG_PLANE_H, 7'(phv));
        write_reg(REG_PLANE_W, 7'(pwv));
    endtask

    // Random pixel: mostly ordinary floats, with NaNs, infinities, zeros and extremes.
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(9))
            0: return {1'($urandom_range(1)), 8'hFF,
                       23'h1 + 23'($urandom_range(32'h7FFFFE))};
            1: return {1'($urandom_range(1)), 31'h7F80_0000};
            2: return {1'($urandom_range(1)), 31'd0};
            3: return $urandom_range(1) ? 32'h7F7F_FFFF : 32'hFF7F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Random phase: random registers, mostly legal, fill the plane, then mixed beats.
    task automatic random_phase(int beats);
        int khv, kwv, srv, scv, prv, pcv, phv, pwv, oh, ow, i;
        khv = $urandom_range(1, 8); kwv = $urandom_range(1, 8);
        srv = $urandom_range(1, 8); scv = $urandom_range(1, 8);
        prv = $urandom_range(0, 7); pcv = $urandom_range(0, 7);
        phv = $urandom_range(1, 12); pwv = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) begin
            // occasional invalid setting: oversize kernel or zero stride
            if ($urandom_range(1)) begin khv = 9 + $urandom_range(6); end
            else begin srv = 0; end
        end
        setup(khv, kwv, srv, scv, prv, pcv, phv, pwv);
        for (int y = 0; y < phv; y++)
            for (int x = 0; x < pwv; x++) write_pixel(y, x, rand_pixel());
        oh = (srv == 0) ? 2 : ((phv + 2 * prv - khv) / srv + 1);
        ow = (scv == 0) ? 2 : ((pwv + 2 * pcv - kwv) / scv + 1);
        if (oh < 1) oh = 1;
        if (ow < 1) ow = 1;
        for (i = 0; i < beats; i++) begin
            case ($urandom_range(9))
                0: write_pixel($urandom_range(phv - 1), $urandom_range(pwv - 1),
                               rand_pixel());
                1: query($urandom_range(63), $urandom_range(63));
                default: query($urandom_range(oh), $urandom_range(ow));
            endcase
        end
    endtask

    initial begin
        board.restore();
        send_idle_pct = 29;
        recv_idle_pct = 80;
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Reset values: 2x2 kernel over a corner of the full 64x64 plane.
        write_pixel(0, 0, 32'h3F80_0000);
        write_pixel(0, 1, 32'h7FC0_0000);
        write_pixel(1, 0, 32'h3F80_0000);
        write_pixel(1, 1, 32'hBF80_0000);
        query(0, 0);
        write_pixel(63, 63, 32'h7F7F_FFFF);
        write_pixel(62, 62, 32'hFF7F_FFFF);
        write_pixel(62, 63, 32'h8000_0000);
        write_pixel(63, 62, 32'h0000_0000);
        query(31, 31);
        query(32, 0);
        query(63, 63);

        // Full padding around a 1x1 plane: every valid window holds the pixel, the last query is bad.
        setup(8, 8, 1, 1, 7, 7, 1, 1);
        write_pixel(0, 0, 32'hFF80_0000);
        query(0, 0);
        query(7, 7);
        query(8, 0);
        // Kernel bigger than the padded plane.
        setup(8, 8, 8, 8, 0, 0, 3, 3);
        query(0, 0);
        // Zero-size plane and oversize plane.
        setup(1, 1, 1, 1, 0, 0, 0, 64);
        query(0, 0);
        setup(1, 1, 1, 1, 0, 0, 65, 64);
        query(0, 0);
        // Padded windows over an all-NaN plane: each window holds one NaN pixel.
        setup(2, 2, 2, 2, 1, 1, 2, 2);
        write_pixel(0, 0, 32'h7FC0_0001);
        write_pixel(0, 1, 32'hFFFF_FFFF);
        write_pixel(1, 0, 32'h7F80_0001);
        write_pixel(1, 1, 32'hFFC0_0000);
        query(0, 0);
        query(1, 1);
        // Write outside the plane but inside the store is kept.
        write_pixel(40, 50, 32'h4000_0000);
        setup(1, 1, 1, 1, 0, 0, 64, 64);
        query(40, 50);
        query(63, 63);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 80; recv_idle_pct = 29; end
            if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            for (int k = 0; k < 3; k++) random_phase(30);
        end

        settle();
        if (board.pending.size() != 0) board.report("results never delivered", 0, 0);
        $display("covered %0d queries, %0d results checked across directed and random phases",
                 queries_sent, board.results_seen);
        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/mpool_pkg.sv
hw/rtl/mpool_ram.sv
hw/rtl/mpool_ctrl.sv
hw/rtl/mpool_dp.sv
hw/rtl/max_pool_2d_argmax.sv
bench/max_pool_2d_argmax_test.sv
